/* src/pla_pkg.sv */
// Shared types and codes for the packed list engine.
`default_nettype none

package pla_pkg;

  localparam int WORD_W  = 32;
  localparam int INDEX_W = 6;
  localparam int OP_W    = 2;
  localparam int COUNT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_READ   = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INDEX_ERR = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EVAL,
    S_APPLY
  } state_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [WORD_W-1:0]  value;
    logic [INDEX_W-1:0] index;
    logic               eval;
    logic               commit;
    logic               found;
  } pla_bcast_t;

endpackage

`default_nettype wire

/* src/packed_list_append_remove.sv */
// Top level of the packed list engine: controller, cell row and result register.
`default_nettype none

// Packed list of signed 32-bit words, CAPACITY entries deep, kept packed from
// position 0 upward in a row of cells. Each input transaction carries an
// operation in in_tuser (append, read at index, remove value) and one result
// transaction comes back with the word read (-1 unless a read succeeds), the
// entry count after the operation (modulo 128) and a status in out_tuser
// (ok, index error, full, not found). An item goes from acceptance to a ready
// result in order: accept, compare in every cell at once, then commit, where
// an append writes the cell at the count, a remove shifts every cell at or
// above the last match down by one in a single step, and a read gathers the
// selected entry through a registered two-level OR tree. A new transaction is
// accepted only when idle, after the previous one has committed; the commit
// cycle holds only when an earlier result is still waiting downstream. Unused
// entries need no clearing after reset, so the block is ready at once.
module packed_list_append_remove #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], index[37:32], zero pad[39:38]
  input  wire logic [1:0]  in_tuser,   // op[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // read_value[31:0], count[38:32], zero pad[39]
  output logic [1:0]       out_tuser   // status[1:0]
);
  import pla_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int GRP   = 32;
  localparam int NGRP  = (CAPACITY + GRP - 1) / GRP;

  // Control and latched command
  state_t              state_r, state_nxt;
  logic [OP_W-1:0]     op_r;
  logic [WORD_W-1:0]   value_r;
  logic [INDEX_W-1:0]  index_r;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                accept;
  logic                commit;
  logic                eval;

  // Cell row
  pla_bcast_t          bc;
  logic [WORD_W-1:0]   cell_data [CAPACITY];
  logic [WORD_W-1:0]   cell_rd   [CAPACITY];
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] above_vec;
  logic                found;

  // Read gather tree
  logic [WORD_W-1:0]   grp_or [NGRP];
  logic [WORD_W-1:0]   grp_r  [NGRP];
  logic [WORD_W-1:0]   rd_word;
  logic                rd_ok;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]   res_value_r, res_value_nxt;
  logic [COUNT_W-1:0]  res_count_r, res_count_nxt;
  logic [1:0]          res_status_r, res_status_nxt;
  logic [COUNT_W-1:0]  cnt7;

  assign accept = in_tvalid && in_tready;
  assign eval   = (state_r == S_EVAL);
  // Commit only when the result register is free or drains this cycle.
  assign commit = (state_r == S_APPLY) && (!out_valid_r || out_tready);

  // Next-state logic
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = S_EVAL;
      S_EVAL:  state_nxt = S_APPLY;
      S_APPLY: if (commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_tready = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the command on acceptance
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_tuser;
      value_r <= in_tdata[31:0];
      index_r <= in_tdata[37:32];
    end
  end

  // Prefix OR: a cell shifts when no match sits above it
  assign found = |match_vec;
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      above_vec[i] = |(match_vec >> (i + 1));
    end
  end

  always_comb begin
    bc        = '0;
    bc.op     = op_r;
    bc.value  = value_r;
    bc.index  = index_r;
    bc.eval   = eval;
    bc.commit = commit;
    bc.found  = found;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WORD_W-1:0] up_data;
    if (i == CAPACITY - 1) begin : g_top
      assign up_data = cell_data[i];
    end else begin : g_mid
      assign up_data = cell_data[i+1];
    end

    pla_cell #(
      .IDX      (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .bc_i      (bc),
      .cnt_i     (cnt_r),
      .up_data_i (up_data),
      .above_i   (above_vec[i]),
      .data_o    (cell_data[i]),
      .match_o   (match_vec[i]),
      .rd_o      (cell_rd[i])
    );
  end

  // First tree level: OR each group of cells, registered during compare
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_or[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < CAPACITY) begin
          grp_or[g] = grp_or[g] | cell_rd[g*GRP+k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eval) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_or[g];
      end
    end
  end

  // Second tree level
  always_comb begin
    rd_word = '0;
    for (int g = 0; g < NGRP; g++) begin
      rd_word = rd_word | grp_r[g];
    end
  end

  assign rd_ok = ({{(32-INDEX_W){1'b0}}, index_r} < 32'(CAPACITY)) &&
                 ({{(32-INDEX_W){1'b0}}, index_r} < 32'(cnt_r));

  // Count update and result formation
  always_comb begin
    cnt_nxt        = cnt_r;
    res_value_nxt  = '1;
    res_status_nxt = ST_INDEX_ERR;
    case (op_r)
      OP_APPEND: begin
        if (cnt_r >= CNT_W'(CAPACITY)) begin
          res_status_nxt = ST_FULL;
        end else begin
          cnt_nxt        = cnt_r + CNT_W'(1);
          res_status_nxt = ST_OK;
        end
      end
      OP_READ: begin
        if (rd_ok) begin
          res_value_nxt  = rd_word;
          res_status_nxt = ST_OK;
        end
      end
      OP_REMOVE: begin
        if (found) begin
          cnt_nxt        = cnt_r - CNT_W'(1);
          res_status_nxt = ST_OK;
        end else begin
          res_status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
        res_status_nxt = ST_INDEX_ERR;
      end
    endcase
  end

  // Report the count modulo 128
  if (CNT_W >= COUNT_W) begin : g_cnt_trunc
    assign cnt7 = cnt_nxt[COUNT_W-1:0];
  end else begin : g_cnt_ext
    assign cnt7 = {{(COUNT_W-CNT_W){1'b0}}, cnt_nxt};
  end
  assign res_count_nxt = cnt7;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // Hold the result until the downstream side takes it
  always_ff @(posedge clk) begin
    if (commit) begin
      res_value_r  <= res_value_nxt;
      res_count_r  <= res_count_nxt;
      res_status_r <= res_status_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, res_count_r, res_value_r};
  assign out_tuser  = res_status_r;

  // Count never runs past the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  // A commit always leaves a result in the output register
  a_commit_out: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed transaction lost its result");

  // A successful remove drops the count by exactly one
  a_remove_dec: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (op_r == OP_REMOVE) && found |=> cnt_r == $past(cnt_r) - CNT_W'(1))
    else $error("remove did not decrement the count");

  // Full is reported only when the list is at capacity
  a_full_cap: assert property (@(posedge clk) disable iff (!rst_n)
    commit && (res_status_nxt == ST_FULL) |-> cnt_r == CNT_W'(CAPACITY))
    else $error("full reported below capacity");

  // Any status other than ok carries the all-ones word
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (res_status_r != ST_OK) |-> res_value_r == '1)
    else $error("error result carries a data word");

endmodule

`default_nettype wire

/* src/pla_cell.sv */
// One list cell: holds an entry, compares it, and takes its upper neighbor's entry on a shift.
`default_nettype none

module pla_cell #(
  parameter int IDX      = 0,
  parameter int CNT_W    = 7
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire pla_pkg::pla_bcast_t       bc_i,
  input  wire logic [CNT_W-1:0]          cnt_i,
  input  wire logic [pla_pkg::WORD_W-1:0] up_data_i,
  input  wire logic                      above_i,
  output logic [pla_pkg::WORD_W-1:0]     data_o,
  output logic                           match_o,
  output logic [pla_pkg::WORD_W-1:0]     rd_o
);
  import pla_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              match_r;
  logic              match_nxt;
  logic              valid;
  logic              hit;

  assign valid = (CNT_W'(IDX) < cnt_i);
  assign hit   = valid && ({{(32-INDEX_W){1'b0}}, bc_i.index} == 32'(IDX));

  always_comb begin
    match_nxt = match_r;
    if (bc_i.eval) begin
      match_nxt = valid && (bc_i.op == OP_REMOVE) && (data_r == bc_i.value);
    end
  end

  always_comb begin
    data_nxt = data_r;
    if (bc_i.commit) begin
      if ((bc_i.op == OP_APPEND) && (cnt_i == CNT_W'(IDX))) begin
        data_nxt = bc_i.value;
      end else if ((bc_i.op == OP_REMOVE) && bc_i.found && !above_i) begin
        // At or above the removed position: pull the neighbor down.
        data_nxt = up_data_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign data_o  = data_r;
  assign match_o = match_r;
  assign rd_o    = hit ? data_r : '0;

endmodule

`default_nettype wire

/* tb/packed_list_append_remove_test.sv */
// Self-checking testbench for the packed list engine: list mirror, stimulus and result checks.

typedef struct {
  logic [31:0]      word;
  logic [6:0]       count;
  pla_pkg::status_t status;
} list_reply_t;

class list_mirror;
  int          depth;
  int          fill;
  int          failures;
  logic [31:0] entries[];
  list_reply_t expected_replies[$];

  function new(int depth_i);
    depth = depth_i;
    fill = 0;
    failures = 0;
    entries = new[depth_i];
  endfunction

  function int pending();
    return expected_replies.size();
  endfunction

  function void note_command(logic [1:0] op, logic [31:0] value, logic [5:0] index);
    list_reply_t r;
    int pos;
    r.word = 32'hFFFF_FFFF;
    r.status = pla_pkg::ST_OK;
    case (op)
      pla_pkg::OP_APPEND: begin
        if (fill >= depth) begin
          r.status = pla_pkg::ST_FULL;
        end else begin
          entries[fill] = value;
          fill++;
        end
      end
      pla_pkg::OP_READ: begin
        if (int'(index) < fill) begin
          r.word = entries[index];
        end else begin
          r.status = pla_pkg::ST_INDEX_ERR;
        end
      end
      pla_pkg::OP_REMOVE: begin
        pos = -1;
        for (int i = 0; i < fill; i++) begin
          if (entries[i] == value) pos = i;
        end
        if (pos < 0) begin
          r.status = pla_pkg::ST_NOT_FOUND;
        end else begin
          for (int i = pos; i + 1 < fill; i++) entries[i] = entries[i + 1];
          fill--;
        end
      end
      default: r.status = pla_pkg::ST_INDEX_ERR;
    endcase
    r.count = 7'(fill);
    expected_replies.push_back(r);
  endfunction

  function void check_response(logic [31:0] word, logic [6:0] count, logic [1:0] status);
    list_reply_t r;
    if (expected_replies.size() == 0) begin
      $error("result with nothing pending: read_value %h count %0d status %0d",
             word, count, status);
      failures++;
      return;
    end
    r = expected_replies.pop_front();
    if (word !== r.word) begin
      $error("read_value: expected %h, got %h", r.word, word);
      failures++;
    end
    if (count !== r.count) begin
      $error("count: expected %0d, got %0d", r.count, count);
      failures++;
    end
    if (status !== r.status) begin
      $error("status: expected %0d, got %0d", r.status, status);
      failures++;
    end
  endfunction
endclass

module packed_list_append_remove_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pla_pkg::*;

  localparam int LIST_DEPTH   = 64;
  localparam int RANDOM_ITEMS = 1400;
  localparam int CYCLE_LIMIT  = 200000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // value[31:0], index[37:32], zero pad[39:38]
  logic [1:0]  in_tuser;   // op[1:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // read_value[31:0], count[38:32], zero pad[39]
  logic [1:0]  out_tuser;  // status[1:0]

  // Set during a stretch of the random part: neither side idles then.
  bit calm;

  list_mirror mirror;

  // Words the random part draws from often, so removes hit duplicates.
  logic [31:0] word_pool[8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_002A};

  packed_list_append_remove #(.CAPACITY(LIST_DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: give up if the run drags far past any correct run.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Verification failed");
    $finish;
  end

  // Result side: stall at random, except during the calm stretch.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 9);
  end

  // Check every result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      mirror.check_response(out_tdata[31:0], out_tdata[38:32], out_tuser);
    end
  end

  // Present one command, hold it until accepted, then record its expected reply.
  task automatic send_command(logic [1:0] op, logic [31:0] value, logic [5:0] index);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 9) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, index, value};
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    mirror.note_command(op, value, index);
  endtask

  // Stop sending and let every outstanding result come back.
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (mirror.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    if ($urandom_range(9) < 6) return word_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    bit          grow;
    int          r;
    logic [1:0]  op;
    logic [31:0] value;
    logic [5:0]  index;

    mirror     = new(LIST_DEPTH);
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    calm       = 1'b0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: empty list, extreme words, last-match remove, absent remove.
    send_command(OP_READ,   32'h0000_0000, 6'd0);   // read on empty list
    send_command(OP_REMOVE, 32'h0000_0005, 6'd0);   // remove on empty list
    send_command(OP_UNUSED, 32'h0000_0000, 6'd0);   // unused op code
    send_command(OP_APPEND, 32'h8000_0000, 6'd0);
    send_command(OP_APPEND, 32'h7FFF_FFFF, 6'd0);
    send_command(OP_APPEND, 32'h0000_0000, 6'd0);
    send_command(OP_APPEND, 32'hFFFF_FFFF, 6'd0);
    send_command(OP_APPEND, 32'h7FFF_FFFF, 6'd0);   // duplicate
    send_command(OP_READ,   32'h0000_0000, 6'd0);
    send_command(OP_READ,   32'h0000_0000, 6'd4);   // last entry
    send_command(OP_READ,   32'h0000_0000, 6'd5);   // one past the end
    send_command(OP_READ,   32'hFFFF_FFFF, 6'd63);  // highest index
    send_command(OP_REMOVE, 32'h7FFF_FFFF, 6'd0);   // takes the later duplicate
    send_command(OP_READ,   32'h0000_0000, 6'd1);
    send_command(OP_READ,   32'h0000_0000, 6'd3);
    send_command(OP_REMOVE, 32'h0000_04D2, 6'd0);   // absent value
    send_command(OP_REMOVE, 32'h8000_0000, 6'd0);   // first entry, shift all
    send_command(OP_READ,   32'h0000_0000, 6'd0);
    send_command(OP_READ,   32'h0000_0000, 6'd2);
    send_command(OP_UNUSED, 32'hFFFF_FFFF, 6'd63);
    send_command(OP_REMOVE, 32'hFFFF_FFFF, 6'd0);   // top entry, no shift

    // Random part: alternate filling to full and draining to empty.
    grow = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      calm = (n >= 500 && n < 800);
      if (n % 350 == 175) drain_results();
      if (mirror.fill == LIST_DEPTH && $urandom_range(7) == 0) grow = 1'b0;
      if (mirror.fill == 0 && $urandom_range(3) == 0) grow = 1'b1;
      r = $urandom_range(99);
      if (grow) begin
        op = (r < 60) ? OP_APPEND : (r < 85) ? OP_READ : (r < 97) ? OP_REMOVE : OP_UNUSED;
      end else begin
        op = (r < 15) ? OP_APPEND : (r < 40) ? OP_READ : (r < 95) ? OP_REMOVE : OP_UNUSED;
      end
      value = pick_word();
      index = 6'($urandom_range(63));
      // Aim most reads and removes at live entries.
      if (mirror.fill > 0 && $urandom_range(9) < 8) begin
        if (op == OP_READ) index = 6'($urandom_range(mirror.fill - 1));
        if (op == OP_REMOVE) value = mirror.entries[$urandom_range(mirror.fill - 1)];
      end
      send_command(op, value, index);
    end
    calm = 1'b0;

    drain_results();
    repeat (10) @(posedge clk);
    if (mirror.failures == 0 && mirror.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
src/pla_pkg.sv
src/pla_cell.sv
src/packed_list_append_remove.sv
tb/packed_list_append_remove_test.sv
